/* src/ftok_pkg.sv */
// ---------------------------------------------------------------------------
// ftok_pkg
// Shared types, token codes and character classes of the formula tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none
package ftok_pkg;

    // token type codes
    localparam logic [4:0] T_END     = 5'd0;
    localparam logic [4:0] T_INVALID = 5'd1;
    localparam logic [4:0] T_CELL    = 5'd2;
    localparam logic [4:0] T_IDENT   = 5'd3;
    localparam logic [4:0] T_NUMBER  = 5'd4;
    localparam logic [4:0] T_NAME    = 5'd5;
    localparam logic [4:0] T_SHEET   = 5'd6;
    localparam logic [4:0] T_STRING  = 5'd7;
    localparam logic [4:0] T_SEMI    = 5'd8;
    localparam logic [4:0] T_OPEN    = 5'd9;
    localparam logic [4:0] T_CLOSE   = 5'd10;
    localparam logic [4:0] T_RANGE   = 5'd11;
    localparam logic [4:0] T_EQ      = 5'd12;
    localparam logic [4:0] T_NE      = 5'd13;
    localparam logic [4:0] T_LE      = 5'd14;
    localparam logic [4:0] T_LT      = 5'd15;
    localparam logic [4:0] T_GE      = 5'd16;
    localparam logic [4:0] T_GT      = 5'd17;
    localparam logic [4:0] T_PLUS    = 5'd18;
    localparam logic [4:0] T_MINUS   = 5'd19;
    localparam logic [4:0] T_MUL     = 5'd20;
    localparam logic [4:0] T_DIV     = 5'd21;
    localparam logic [4:0] T_CAT     = 5'd22;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // special character kinds
    typedef enum logic [3:0] {
        K_OTHER, K_SPACE, K_DOLLAR, K_AT, K_DOT, K_UNDER, K_BANG,
        K_QUOTE, K_LT, K_GT, K_EQ, K_SIGN
    } t_kind;

    // one classified input transaction
    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
        logic       letter;
        logic       digit;
        t_kind      kind;
        logic [4:0] stype;
    } t_tok_in;

    // type of a one-character operator
    function automatic logic [4:0] single_type(input logic [7:0] c);
        logic [4:0] t;
        case (c)
            8'h3B: t = T_SEMI;
            8'h28: t = T_OPEN;
            8'h29: t = T_CLOSE;
            8'h3A: t = T_RANGE;
            8'h3D: t = T_EQ;
            8'h2B: t = T_PLUS;
            8'h2D: t = T_MINUS;
            8'h2A: t = T_MUL;
            8'h2F: t = T_DIV;
            8'h26: t = T_CAT;
            default: t = T_INVALID;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

/* src/ftok_front.sv */
// ---------------------------------------------------------------------------
// ftok_front
// Accepts input characters and classifies them for the lexer.
// ---------------------------------------------------------------------------
`default_nettype none
module ftok_front (
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // in_char
    input  wire logic             s_tuser,   // is_end
    input  wire logic             i_q_full,
    output logic                  o_q_push,
    output ftok_pkg::t_tok_in     o_q_data
);
    // accept whenever the queue has room
    assign s_tready = !i_q_full;
    assign o_q_push = s_tvalid && !i_q_full;

    // character classification
    always_comb begin
        logic [7:0] c;
        c = s_tdata;
        o_q_data.ch     = c;
        o_q_data.is_end = s_tuser;
        o_q_data.letter = !s_tuser && ((c >= 8'h41 && c <= 8'h5A) ||
                                       (c >= 8'h61 && c <= 8'h7A));
        o_q_data.digit  = !s_tuser && (c >= 8'h30 && c <= 8'h39);
        o_q_data.stype  = ftok_pkg::single_type(c);
        o_q_data.kind   = ftok_pkg::K_OTHER;
        if (!s_tuser) begin
            case (c)
                8'h20, 8'h09: o_q_data.kind = ftok_pkg::K_SPACE;
                8'h24:        o_q_data.kind = ftok_pkg::K_DOLLAR;
                8'h40:        o_q_data.kind = ftok_pkg::K_AT;
                8'h2E, 8'h2C: o_q_data.kind = ftok_pkg::K_DOT;
                8'h5F:        o_q_data.kind = ftok_pkg::K_UNDER;
                8'h21:        o_q_data.kind = ftok_pkg::K_BANG;
                8'h22:        o_q_data.kind = ftok_pkg::K_QUOTE;
                8'h3C:        o_q_data.kind = ftok_pkg::K_LT;
                8'h3E:        o_q_data.kind = ftok_pkg::K_GT;
                8'h3D:        o_q_data.kind = ftok_pkg::K_EQ;
                8'h2B, 8'h2D: o_q_data.kind = ftok_pkg::K_SIGN;
                default:      o_q_data.kind = ftok_pkg::K_OTHER;
            endcase
        end
    end
endmodule
`default_nettype wire

/* src/ftok_fifo.sv */
// ---------------------------------------------------------------------------
// ftok_fifo
// Short register queue of classified characters between front and back.
// ---------------------------------------------------------------------------
`default_nettype none
module ftok_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire ftok_pkg::t_tok_in  i_data,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output ftok_pkg::t_tok_in       o_data
);
    ftok_pkg::t_tok_in                 r_mem [ftok_pkg::QDEPTH];
    logic [ftok_pkg::QPTR_W-1:0]       r_wr;
    logic [ftok_pkg::QPTR_W-1:0]       r_rd;
    logic [ftok_pkg::QCNT_W-1:0]       r_cnt;

    assign o_full  = (r_cnt == ftok_pkg::QCNT_W'(ftok_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end
endmodule
`default_nettype wire

/* src/ftok_back.sv */
// ---------------------------------------------------------------------------
// ftok_back
// Lexer state machine: one step per cycle unless starved or stalled; at most one
// result transaction per step; exponent lookahead replay; registered output.
// ---------------------------------------------------------------------------
`default_nettype none
module ftok_back #(
    parameter int POSITION_BITS = 16,
    parameter int MAX_LETTERS   = 4,
    parameter int MAX_DIGITS    = 12
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_q_valid,
    input  wire ftok_pkg::t_tok_in  i_q_data,
    output logic                    o_q_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [31:0]             m_tdata,   // text_char, token_type, token_start
    output logic                    m_tuser,   // char_valid
    output logic                    m_tlast    // token_end
);
    localparam int PB = POSITION_BITS;
    localparam int LW = $clog2(MAX_LETTERS + 2);
    localparam int DW = $clog2(MAX_DIGITS + 2);
    localparam logic [PB-1:0] POS_MAX = '1;

    typedef enum logic [3:0] {
        M_IDLE, M_CELL_LET, M_CELL_DIG, M_IDENT, M_NAME, M_SHEET, M_NUM_INT,
        M_NUM_FRAC, M_EXP_E, M_EXP_SIGN, M_EXP_SOUT, M_EXP_DIG, M_STR,
        M_STR_QUOTE, M_LT, M_GT
    } t_mode;

    t_mode              r_mode, n_mode;
    logic [PB-1:0]      r_pos, n_pos;
    logic [PB-1:0]      r_begin, n_begin;
    logic [LW-1:0]      r_let, n_let;
    logic [DW-1:0]      r_dig, n_dig;
    ftok_pkg::t_tok_in  r_hold [2];
    ftok_pkg::t_tok_in  n_hold [2];
    logic [1:0]         r_held, n_held;
    logic [1:0]         r_rep_n, n_rep_n;
    logic [1:0]         r_rep_i, n_rep_i;
    logic               r_nonempty, n_nonempty;
    logic               r_ov;
    logic [7:0]         r_o_ch;
    logic               r_o_val;
    logic               r_o_end;
    logic [4:0]         r_o_type;
    logic [15:0]        r_o_start;

    logic               rep_active, have, fire, consume;
    ftok_pkg::t_tok_in  cur;
    logic [1:0]         adv;
    logic               e_go, e_val, e_end, e_use_pos;
    logic [7:0]         e_ch;
    logic [4:0]         e_type;
    logic               cell_ok;
    logic [PB:0]        pos_sum;
    logic [PB-1:0]      e_start;
    logic [32:0]        start_ext;
    logic [32:0]        cfg_ext;

    // current character: replayed lookahead first, then queue head
    assign rep_active = (r_rep_i != r_rep_n);
    assign cur        = rep_active ? r_hold[r_rep_i[0]] : i_q_data;
    assign have       = rep_active || i_q_valid;
    assign fire       = have && (!r_ov || m_tready);
    assign o_q_pop    = fire && consume && !rep_active;

    assign cell_ok = (r_let >= LW'(1)) && (r_let <= LW'(MAX_LETTERS)) &&
                     (r_dig >= DW'(1)) && (r_dig <= DW'(MAX_DIGITS));

    // lexer step
    always_comb begin
        n_mode = r_mode; n_begin = r_begin; n_let = r_let; n_dig = r_dig;
        n_hold = r_hold; n_held = r_held; n_rep_n = r_rep_n;
        n_nonempty = r_nonempty;
        n_rep_i = r_rep_i;
        consume = 1'b0; adv = 2'd0;
        e_go = 1'b0; e_val = 1'b0; e_end = 1'b0; e_use_pos = 1'b0;
        e_ch = 8'h00; e_type = ftok_pkg::T_END;
        case (r_mode)
            M_IDLE: begin
                consume = 1'b1;
                if (cur.is_end) begin
                    n_begin = r_pos; n_let = '0; n_dig = '0; n_nonempty = 1'b0;
                    e_go = 1'b1; e_end = 1'b1; e_use_pos = 1'b1;
                end else if (cur.kind == ftok_pkg::K_SPACE) begin
                    adv = 2'd1;
                end else begin
                    adv = 2'd1;
                    n_begin = r_pos; n_let = '0; n_dig = '0; n_nonempty = 1'b0;
                    if (cur.letter) begin
                        e_go = 1'b1; e_val = 1'b1; e_ch = cur.ch & 8'hDF;
                        n_let = LW'(1); n_mode = M_CELL_LET;
                    end else if (cur.digit) begin
                        e_go = 1'b1; e_val = 1'b1; e_ch = cur.ch;
                        n_dig = DW'(1); n_mode = M_NUM_INT;
                    end else begin
                        case (cur.kind)
                            ftok_pkg::K_DOLLAR: begin
                                e_go = 1'b1; e_val = 1'b1; e_ch = cur.ch;
                                n_mode = M_CELL_LET;
                            end
                            ftok_pkg::K_AT:    n_mode = M_IDENT;
                            ftok_pkg::K_DOT: begin
                                e_go = 1'b1; e_val = 1'b1; e_ch = 8'h2E;
                                n_mode = M_NUM_FRAC;
                            end
                            ftok_pkg::K_UNDER: n_mode = M_NAME;
                            ftok_pkg::K_BANG:  n_mode = M_SHEET;
                            ftok_pkg::K_QUOTE: n_mode = M_STR;
                            ftok_pkg::K_LT: begin
                                e_go = 1'b1; e_val = 1'b1; e_ch = cur.ch;
                                n_mode = M_LT;
                            end
                            ftok_pkg::K_GT: begin
                                e_go = 1'b1; e_val = 1'b1; e_ch = cur.ch;
                                n_mode = M_GT;
                            end
                            default: begin
                                e_go = 1'b1; e_val = 1'b1; e_end = 1'b1;
                                e_use_pos = 1'b1; e_ch = cur.ch; e_type = cur.stype;
                            end
                        endcase
                    end
                end
            end
            M_CELL_LET: begin
                if (cur.letter) begin
                    e_go = 1'b1; e_val = 1'b1; e_ch = cur.ch & 8'hDF;
                    if (r_let <= LW'(MAX_LETTERS)) n_let = r_let + 1'b1;
                    adv = 2'd1; consume = 1'b1;
                end else if (cur.kind == ftok_pkg::K_DOLLAR) begin
                    e_go = 1'b1; e_val = 1'b1; e_ch = cur.ch;
                    adv = 2'd1; consume = 1'b1; n_mode = M_CELL_DIG;
                end else if (cur.digit) begin
                    e_go = 1'b1; e_val = 1'b1; e_ch = cur.ch; n_dig = DW'(1);
                    adv = 2'd1; consume = 1'b1; n_mode = M_CELL_DIG;
                end else begin
                    e_go = 1'b1; e_end = 1'b1; n_mode = M_IDLE;
                    e_type = cell_ok ? ftok_pkg::T_CELL : ftok_pkg::T_INVALID;
                end
            end
            M_CELL_DIG: begin
                if (cur.digit) begin
                    e_go = 1'b1; e_val = 1'b1; e_ch = cur.ch;
                    if (r_dig <= DW'(MAX_DIGITS)) n_dig = r_dig + 1'b1;
                    adv = 2'd1; consume = 1'b1;
                end else begin
                    e_go = 1'b1; e_end = 1'b1; n_mode = M_IDLE;
                    e_type = cell_ok ? ftok_pkg::T_CELL : ftok_pkg::T_INVALID;
                end
            end
            M_IDENT: begin
                if (cur.letter) begin
                    e_go = 1'b1; e_val = 1'b1; e_ch = cur.ch & 8'hDF;
                    n_nonempty = 1'b1; adv = 2'd1; consume = 1'b1;
                end else begin
                    e_go = 1'b1; e_end = 1'b1; n_mode = M_IDLE;
                    e_type = r_nonempty ? ftok_pkg::T_IDENT : ftok_pkg::T_INVALID;
                end
            end
            M_NAME, M_SHEET: begin
                if (cur.letter || cur.digit || cur.kind == ftok_pkg::K_UNDER ||
                    cur.kind == ftok_pkg::K_DOLLAR) begin
                    e_go = 1'b1; e_val = 1'b1; e_ch = cur.ch;
                    n_nonempty = 1'b1; adv = 2'd1; consume = 1'b1;
                end else begin
                    e_go = 1'b1; e_end = 1'b1; n_mode = M_IDLE;
                    if (!r_nonempty)         e_type = ftok_pkg::T_INVALID;
                    else if (r_mode == M_NAME) e_type = ftok_pkg::T_NAME;
                    else                     e_type = ftok_pkg::T_SHEET;
                end
            end
            M_NUM_INT, M_NUM_FRAC: begin
                if (cur.digit) begin
                    e_go = 1'b1; e_val = 1'b1; e_ch = cur.ch;
                    if (r_mode == M_NUM_FRAC) n_dig = DW'(1);
                    adv = 2'd1; consume = 1'b1;
                end else if (r_mode == M_NUM_INT && cur.kind == ftok_pkg::K_DOT) begin
                    e_go = 1'b1; e_val = 1'b1; e_ch = 8'h2E;
                    adv = 2'd1; consume = 1'b1; n_mode = M_NUM_FRAC;
                end else if (r_dig == '0) begin
                    e_go = 1'b1; e_end = 1'b1; n_mode = M_IDLE;
                    e_type = ftok_pkg::T_INVALID;
                end else if (cur.letter && (cur.ch & 8'hDF) == 8'h45) begin
                    // hold the exponent mark until a digit confirms it
                    n_hold[0] = cur; n_held = 2'd1; consume = 1'b1;
                    n_mode = M_EXP_E;
                end else begin
                    e_go = 1'b1; e_end = 1'b1; n_mode = M_IDLE;
                    e_type = ftok_pkg::T_NUMBER;
                end
            end
            M_EXP_E, M_EXP_SIGN: begin
                if (r_mode == M_EXP_E && cur.kind == ftok_pkg::K_SIGN) begin
                    n_hold[1] = cur; n_held = 2'd2; consume = 1'b1;
                    n_mode = M_EXP_SIGN;
                end else if (cur.digit) begin
                    // exponent confirmed: emit mark, then sign, then digits
                    e_go = 1'b1; e_val = 1'b1; e_ch = 8'h65;
                    adv = r_held; n_held = 2'd0;
                    n_mode = (r_held == 2'd2) ? M_EXP_SOUT : M_EXP_DIG;
                end else begin
                    // lookahead failed: close number, replay held characters
                    e_go = 1'b1; e_end = 1'b1; e_type = ftok_pkg::T_NUMBER;
                    n_mode = M_IDLE; n_rep_n = r_held; n_rep_i = 2'd0;
                    n_held = 2'd0;
                end
            end
            M_EXP_SOUT: begin
                e_go = 1'b1; e_val = 1'b1; e_ch = r_hold[1].ch;
                n_mode = M_EXP_DIG;
            end
            M_EXP_DIG: begin
                if (cur.digit) begin
                    e_go = 1'b1; e_val = 1'b1; e_ch = cur.ch;
                    adv = 2'd1; consume = 1'b1;
                end else begin
                    e_go = 1'b1; e_end = 1'b1; n_mode = M_IDLE;
                    e_type = ftok_pkg::T_NUMBER;
                end
            end
            M_STR: begin
                if (cur.is_end) begin
                    e_go = 1'b1; e_end = 1'b1; n_mode = M_IDLE;
                    e_type = ftok_pkg::T_INVALID;
                end else if (cur.kind == ftok_pkg::K_QUOTE) begin
                    adv = 2'd1; consume = 1'b1; n_mode = M_STR_QUOTE;
                end else begin
                    e_go = 1'b1; e_val = 1'b1; e_ch = cur.ch;
                    adv = 2'd1; consume = 1'b1;
                end
            end
            M_STR_QUOTE: begin
                if (cur.kind == ftok_pkg::K_QUOTE) begin
                    e_go = 1'b1; e_val = 1'b1; e_ch = cur.ch;
                    adv = 2'd1; consume = 1'b1; n_mode = M_STR;
                end else begin
                    e_go = 1'b1; e_end = 1'b1; n_mode = M_IDLE;
                    e_type = ftok_pkg::T_STRING;
                end
            end
            M_LT: begin
                e_go = 1'b1; e_end = 1'b1; n_mode = M_IDLE;
                if (cur.kind == ftok_pkg::K_GT || cur.kind == ftok_pkg::K_EQ) begin
                    e_val = 1'b1; e_ch = cur.ch; adv = 2'd1; consume = 1'b1;
                    e_type = (cur.kind == ftok_pkg::K_GT) ? ftok_pkg::T_NE
                                                          : ftok_pkg::T_LE;
                end else begin
                    e_type = ftok_pkg::T_LT;
                end
            end
            M_GT: begin
                e_go = 1'b1; e_end = 1'b1; n_mode = M_IDLE;
                if (cur.kind == ftok_pkg::K_EQ) begin
                    e_val = 1'b1; e_ch = cur.ch; adv = 2'd1; consume = 1'b1;
                    e_type = ftok_pkg::T_GE;
                end else begin
                    e_type = ftok_pkg::T_GT;
                end
            end
            default: n_mode = M_IDLE;
        endcase
        if (consume && rep_active) n_rep_i = r_rep_i + 1'b1;
    end

    // saturating position advance and start field
    assign pos_sum   = {1'b0, r_pos} + (PB + 1)'(adv);
    assign n_pos     = pos_sum[PB] ? POS_MAX : pos_sum[PB-1:0];
    assign e_start   = e_use_pos ? r_pos : r_begin;
    assign start_ext = 33'(e_start);
    assign cfg_ext   = 33'(i_cfg_data);

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_IDLE;
            r_pos      <= '0;
            r_begin    <= '0;
            r_let      <= '0;
            r_dig      <= '0;
            r_held     <= '0;
            r_rep_n    <= '0;
            r_rep_i    <= '0;
            r_nonempty <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pos <= (cfg_ext > 33'(POS_MAX)) ? POS_MAX : cfg_ext[PB-1:0];
            end else if (fire) begin
                r_pos <= n_pos;
            end
            if (fire) begin
                r_mode     <= n_mode;
                r_begin    <= n_begin;
                r_let      <= n_let;
                r_dig      <= n_dig;
                r_held     <= n_held;
                r_nonempty <= n_nonempty;
                if (n_rep_i == n_rep_n) begin
                    r_rep_n <= '0;
                    r_rep_i <= '0;
                end else begin
                    r_rep_n <= n_rep_n;
                    r_rep_i <= n_rep_i;
                end
            end
            if (fire && e_go)  r_ov <= 1'b1;
            else if (m_tready) r_ov <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_hold <= n_hold;
        end
        if (fire && e_go) begin
            r_o_val   <= e_val;
            r_o_end   <= e_end;
            r_o_ch    <= e_val ? e_ch : 8'h00;
            r_o_type  <= e_end ? e_type : ftok_pkg::T_END;
            r_o_start <= !e_end ? 16'h0000 :
                         (start_ext > 33'h0FFFF) ? 16'hFFFF : start_ext[15:0];
        end
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = {3'b000, r_o_start, r_o_type, r_o_ch};
    assign m_tuser  = r_o_val;
    assign m_tlast  = r_o_end;

`ifndef SYNTHESIS
    // replay index never runs past the replay length
    a_rep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rep_i <= r_rep_n)
        else $error("replay index beyond replay length");

    // one held character in the exponent-mark mode, two in the exponent-sign mode
    a_held_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_mode == M_EXP_E) == (r_held == 2'd1)) &&
        ((r_mode == M_EXP_SIGN) == (r_held == 2'd2)))
        else $error("held count out of step with lexer mode");

    // every result carries a character or ends a token
    a_no_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_o_val || r_o_end))
        else $error("empty result transaction");

    // a stalled result is not overwritten
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_tready) |=> (r_ov && $stable(r_o_ch) && $stable(r_o_type)))
        else $error("stalled result changed");
`endif
endmodule
`default_nettype wire

/* src/formula_tokenizer_core.sv */
// A character is registered in the queue, then its first result in the output register.
// Throughput: one character per cycle while the 4-deep queue has room; a character
// that closes a token is lexed again to open the next, and a failed exponent
// lookahead replays its held characters; the queue absorbs these extra lexer steps.
// Reset: synchronous active-low; clears queue, lexer mode, counters and output valid.
// ---------------------------------------------------------------------------
// formula_tokenizer_core
// Streaming formula tokenizer: front classifier, queue and lexer back end.
// ---------------------------------------------------------------------------
`default_nettype none
module formula_tokenizer_core #(
    parameter int POSITION_BITS = 16,
    parameter int MAX_LETTERS   = 4,
    parameter int MAX_DIGITS    = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,   // start_position
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,      // in_char
    input  wire logic        s_tuser,      // is_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,      // text_char, token_type, token_start, zeros
    output logic             m_tuser,      // char_valid
    output logic             m_tlast       // token_end
);
    logic               q_full, q_push, q_pop, q_valid;
    ftok_pkg::t_tok_in  q_in, q_out;

    assign o_cfg_ready = 1'b1;

    ftok_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_in)
    );

    ftok_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    ftok_back #(
        .POSITION_BITS (POSITION_BITS),
        .MAX_LETTERS   (MAX_LETTERS),
        .MAX_DIGITS    (MAX_DIGITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_q_data   (q_out),
        .o_q_pop    (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Self-checking testbench for formula_tokenizer_core. Characters and end
// marks go in on the slave stream; a local lexer predicts every token-text
// and token-end transaction, and each master transaction is compared with
// the oldest prediction. Directed tests cover each token kind and corner
// case. Random formulas with noise then run with random idling on both
// sides, off for part of the run, and two start positions.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int END_CODE    = 256;
    localparam int LETTER_SAT  = 5;
    localparam int DIGIT_SAT   = 13;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 12;

    // lexer modes of the predictor
    typedef enum int {
        LX_IDLE, LX_CELL_LET, LX_CELL_DIG, LX_IDENT, LX_NAME, LX_SHEET, LX_NUM_INT,
        LX_NUM_FRAC, LX_EXP_E, LX_EXP_SIGN, LX_EXP_DIG, LX_STR, LX_STR_QUOTE,
        LX_LT, LX_GT
    } t_lex_mode;

    typedef struct {
        logic [7:0]  text;
        logic        valid;
        logic        tend;
        logic [4:0]  ttype;
        logic [15:0] tstart;
    } t_token_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // in_char
    logic        s_tuser = 1'b0;    // is_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // text_char, token_type, token_start, zeros
    logic        m_tuser;           // char_valid
    logic        m_tlast;           // token_end

    formula_tokenizer_core DUT (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    t_lex_mode   lex_mode;
    logic [15:0] char_pos;
    logic [15:0] tok_begin;
    int          n_letters;
    int          n_digits;
    logic [7:0]  held[2];
    int          n_held;
    bit          has_text;
    int          beats_this_char;
    t_token_beat token_beats_q[$];

    int  fail_count = 0;
    int  cycle_count = 0;
    bit  idle_on = 1'b1;

    // ---------------- predictor ----------------
    function automatic bit is_letter(int c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_digit(int c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic int to_upper(int c);
        return (c >= "a" && c <= "z") ? c - 32 : c;
    endfunction

    function automatic void step_pos();
        if (char_pos != 16'hFFFF) char_pos++;
    endfunction

    function automatic void push_beat(int ch, bit valid, bit tend, logic [4:0] ttype);
        t_token_beat b;
        if (beats_this_char >= 6) return;
        b.text   = valid ? ch[7:0] : 8'h00;
        b.valid  = valid;
        b.tend   = tend;
        b.ttype  = tend ? ttype : 5'd0;
        b.tstart = tend ? tok_begin : 16'd0;
        token_beats_q.push_back(b);
        beats_this_char++;
    endfunction

    function automatic logic [4:0] op_type(int c);
        case (c)
            ";": return ftok_pkg::T_SEMI;
            "(": return ftok_pkg::T_OPEN;
            ")": return ftok_pkg::T_CLOSE;
            ":": return ftok_pkg::T_RANGE;
            "=": return ftok_pkg::T_EQ;
            "+": return ftok_pkg::T_PLUS;
            "-": return ftok_pkg::T_MINUS;
            "*": return ftok_pkg::T_MUL;
            "/": return ftok_pkg::T_DIV;
            "&": return ftok_pkg::T_CAT;
            default: return ftok_pkg::T_INVALID;
        endcase
    endfunction

    function automatic void begin_token(int ch);
        lex_mode = LX_IDLE;
        if (ch == " " || ch == 9) begin
            step_pos();
            return;
        end
        tok_begin = char_pos;
        n_letters = 0;
        n_digits  = 0;
        has_text  = 0;
        if (ch == END_CODE) begin
            push_beat(0, 0, 1, ftok_pkg::T_END);
            return;
        end
        if (is_letter(ch)) begin
            push_beat(to_upper(ch), 1, 0, 0); n_letters = 1; lex_mode = LX_CELL_LET;
        end else if (ch == "$") begin
            push_beat(ch, 1, 0, 0); lex_mode = LX_CELL_LET;
        end else if (ch == "@") begin
            lex_mode = LX_IDENT;
        end else if (is_digit(ch)) begin
            push_beat(ch, 1, 0, 0); n_digits = 1; lex_mode = LX_NUM_INT;
        end else if (ch == "." || ch == ",") begin
            push_beat(".", 1, 0, 0); lex_mode = LX_NUM_FRAC;
        end else if (ch == "_") begin
            lex_mode = LX_NAME;
        end else if (ch == "!") begin
            lex_mode = LX_SHEET;
        end else if (ch == 34) begin
            lex_mode = LX_STR;
        end else if (ch == "<") begin
            push_beat(ch, 1, 0, 0); lex_mode = LX_LT;
        end else if (ch == ">") begin
            push_beat(ch, 1, 0, 0); lex_mode = LX_GT;
        end else begin
            push_beat(ch, 1, 1, op_type(ch));
        end
        step_pos();
    endfunction

    function automatic void close_token(logic [4:0] ttype, int ch);
        push_beat(0, 0, 1, ttype);
        begin_token(ch);
    endfunction

    function automatic logic [4:0] cell_kind();
        return (n_letters >= 1 && n_letters <= 4 && n_digits >= 1 && n_digits <= 12)
            ? ftok_pkg::T_CELL : ftok_pkg::T_INVALID;
    endfunction

    function automatic void number_done(int ch);
        if (n_digits == 0) begin
            close_token(ftok_pkg::T_INVALID, ch);
        end else if (ch == "e" || ch == "E") begin
            held[0] = ch[7:0]; n_held = 1; lex_mode = LX_EXP_E;
        end else begin
            close_token(ftok_pkg::T_NUMBER, ch);
        end
    endfunction

    function automatic void exponent_taken(int ch);
        push_beat("e", 1, 0, 0);
        if (n_held == 2) push_beat(held[1], 1, 0, 0);
        repeat (n_held) step_pos();
        n_held = 0;
        push_beat(ch, 1, 0, 0);
        step_pos();
        lex_mode = LX_EXP_DIG;
    endfunction

    // failed exponent: close the number and replay the held characters
    function automatic void exponent_dropped(int ch);
        logic [7:0] saved[2];
        int cnt;
        saved = held;
        cnt = n_held;
        n_held = 0;
        push_beat(0, 0, 1, ftok_pkg::T_NUMBER);
        lex_mode = LX_IDLE;
        for (int k = 0; k < cnt; k++) lex_char(saved[k]);
        lex_char(ch);
    endfunction

    function automatic void lex_char(int ch);
        bit e;
        e = (ch == END_CODE);
        case (lex_mode)
            LX_CELL_LET: begin
                if (!e && is_letter(ch)) begin
                    push_beat(to_upper(ch), 1, 0, 0);
                    if (n_letters < LETTER_SAT) n_letters++;
                    step_pos();
                end else if (!e && ch == "$") begin
                    push_beat(ch, 1, 0, 0); step_pos(); lex_mode = LX_CELL_DIG;
                end else if (!e && is_digit(ch)) begin
                    push_beat(ch, 1, 0, 0); n_digits = 1; step_pos(); lex_mode = LX_CELL_DIG;
                end else close_token(cell_kind(), ch);
            end
            LX_CELL_DIG: begin
                if (!e && is_digit(ch)) begin
                    push_beat(ch, 1, 0, 0);
                    if (n_digits < DIGIT_SAT) n_digits++;
                    step_pos();
                end else close_token(cell_kind(), ch);
            end
            LX_IDENT: begin
                if (!e && is_letter(ch)) begin
                    push_beat(to_upper(ch), 1, 0, 0); has_text = 1; step_pos();
                end else close_token(has_text ? ftok_pkg::T_IDENT : ftok_pkg::T_INVALID, ch);
            end
            LX_NAME, LX_SHEET: begin
                if (!e && (ch == "_" || ch == "$" || is_letter(ch) || is_digit(ch))) begin
                    push_beat(ch, 1, 0, 0); has_text = 1; step_pos();
                end else close_token(!has_text ? ftok_pkg::T_INVALID
                                     : (lex_mode == LX_NAME ? ftok_pkg::T_NAME
                                                            : ftok_pkg::T_SHEET), ch);
            end
            LX_NUM_INT: begin
                if (!e && is_digit(ch)) begin
                    push_beat(ch, 1, 0, 0); step_pos();
                end else if (!e && (ch == "." || ch == ",")) begin
                    push_beat(".", 1, 0, 0); step_pos(); lex_mode = LX_NUM_FRAC;
                end else number_done(ch);
            end
            LX_NUM_FRAC: begin
                if (!e && is_digit(ch)) begin
                    push_beat(ch, 1, 0, 0); n_digits = 1; step_pos();
                end else number_done(ch);
            end
            LX_EXP_E: begin
                if (!e && (ch == "+" || ch == "-")) begin
                    held[1] = ch[7:0]; n_held = 2; lex_mode = LX_EXP_SIGN;
                end else if (!e && is_digit(ch)) exponent_taken(ch);
                else exponent_dropped(ch);
            end
            LX_EXP_SIGN: begin
                if (!e && is_digit(ch)) exponent_taken(ch);
                else exponent_dropped(ch);
            end
            LX_EXP_DIG: begin
                if (!e && is_digit(ch)) begin
                    push_beat(ch, 1, 0, 0); step_pos();
                end else close_token(ftok_pkg::T_NUMBER, ch);
            end
            LX_STR: begin
                if (e) close_token(ftok_pkg::T_INVALID, ch);
                else if (ch == 34) begin
                    step_pos(); lex_mode = LX_STR_QUOTE;
                end else begin
                    push_beat(ch, 1, 0, 0); step_pos();
                end
            end
            LX_STR_QUOTE: begin
                if (!e && ch == 34) begin
                    push_beat(ch, 1, 0, 0); step_pos(); lex_mode = LX_STR;
                end else close_token(ftok_pkg::T_STRING, ch);
            end
            LX_LT: begin
                if (!e && ch == ">") begin
                    push_beat(ch, 1, 1, ftok_pkg::T_NE); step_pos(); lex_mode = LX_IDLE;
                end else if (!e && ch == "=") begin
                    push_beat(ch, 1, 1, ftok_pkg::T_LE); step_pos(); lex_mode = LX_IDLE;
                end else close_token(ftok_pkg::T_LT, ch);
            end
            LX_GT: begin
                if (!e && ch == "=") begin
                    push_beat(ch, 1, 1, ftok_pkg::T_GE); step_pos(); lex_mode = LX_IDLE;
                end else close_token(ftok_pkg::T_GT, ch);
            end
            default: begin
                begin_token(ch);
            end
        endcase
    endfunction

    // ---------------- stimulus ----------------
    task automatic send_char(int ch, logic [7:0] end_junk = 8'h00);
        if (idle_on && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= (ch == END_CODE);
        s_tdata  <= (ch == END_CODE) ? end_junk : ch[7:0];
        do @(posedge i_clk); while (!s_tready);
        beats_this_char = 0;
        lex_char(ch);
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++) send_char(s[k]);
    endtask

    // stop sending until every predicted transaction has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (token_beats_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_start_pos(logic [15:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        char_pos = value;
    endtask

    task automatic test_cells();
        send_text("A1 $ab$12+abcde1 xyzw9 A1234567890123 q");
        send_char(END_CODE);
    endtask

    task automatic test_sigils();
        send_text("@foo @ _x$1 _ !S1 ! ");
        send_char(END_CODE);
    endtask

    task automatic test_numbers();
        send_text("1,5e+3 2e 3e-x 4E7 .,9.");
        send_char(END_CODE);
    endtask

    task automatic test_strings();
        send_text("\"a\"\"b\" \"\"\"open");
        send_char(END_CODE, 8'hFF);
        send_char(END_CODE);
    endtask

    task automatic test_operators();
        send_text("<> <= < >= > ;()=:+-*/&\t");
        send_char(END_CODE);
    endtask

    task automatic test_odd_bytes();
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h80);
        send_char(8'h7F);
        send_char(END_CODE, 8'hA5);
    endtask

    task automatic test_position_saturation();
        write_start_pos(16'hFFFF);
        send_text("A1 2");
        send_char(END_CODE);
        write_start_pos(16'hFFFA);
        send_text("ab12 @x 1e+5 \"s\"");
        send_char(END_CODE);
    endtask

    function automatic int rand_letter();
        return $urandom_range(1) ? $urandom_range("a", "z") : $urandom_range("A", "Z");
    endfunction

    // one random token, mostly well formed
    task automatic gen_token(ref int buf_q[$]);
        string ops = ";()=:+-*/&";
        case ($urandom_range(11))
            0, 1: begin
                if ($urandom_range(3) == 0) buf_q.push_back("$");
                repeat ($urandom_range(1, 5)) buf_q.push_back(rand_letter());
                if ($urandom_range(3) == 0) buf_q.push_back("$");
                repeat ($urandom_range(0, 14)) buf_q.push_back($urandom_range("0", "9"));
            end
            2, 3: begin
                repeat ($urandom_range(0, 3)) buf_q.push_back($urandom_range("0", "9"));
                if ($urandom_range(1)) buf_q.push_back($urandom_range(1) ? "." : ",");
                repeat ($urandom_range(0, 3)) buf_q.push_back($urandom_range("0", "9"));
                if ($urandom_range(1)) begin
                    buf_q.push_back($urandom_range(1) ? "e" : "E");
                    if ($urandom_range(1)) buf_q.push_back($urandom_range(1) ? "+" : "-");
                    repeat ($urandom_range(0, 2)) buf_q.push_back($urandom_range("0", "9"));
                end
            end
            4: begin
                buf_q.push_back("@");
                repeat ($urandom_range(0, 4)) buf_q.push_back(rand_letter());
            end
            5: begin
                buf_q.push_back($urandom_range(1) ? "_" : "!");
                repeat ($urandom_range(0, 4))
                    case ($urandom_range(3))
                        0: buf_q.push_back("_");
                        1: buf_q.push_back("$");
                        2: buf_q.push_back($urandom_range("0", "9"));
                        default: buf_q.push_back(rand_letter());
                    endcase
            end
            6: begin
                buf_q.push_back(34);
                repeat ($urandom_range(0, 4))
                    buf_q.push_back($urandom_range(3) == 0 ? 34 : $urandom_range(32, 126));
                if ($urandom_range(5) != 0) buf_q.push_back(34);
            end
            7, 8: begin
                case ($urandom_range(3))
                    0: buf_q.push_back("<");
                    1: buf_q.push_back(">");
                    default: buf_q.push_back(ops[$urandom_range(9)]);
                endcase
                if ($urandom_range(2) == 0) buf_q.push_back($urandom_range(1) ? "=" : ">");
            end
            9: buf_q.push_back($urandom_range(1) ? " " : 9);
            10: buf_q.push_back(END_CODE);
            default: buf_q.push_back($urandom_range(255));
        endcase
        if ($urandom_range(2) == 0) buf_q.push_back(" ");
    endtask

    task automatic test_random(int n_items);
        int buf_q[$];
        int sent;
        sent = 0;
        while (sent < n_items) begin
            if (sent >= n_items / 3 && sent < n_items / 3 + 70) idle_on = 1'b0;
            else idle_on = 1'b1;
            if (buf_q.size() == 0) gen_token(buf_q);
            if (buf_q[0] == END_CODE) send_char(END_CODE, 8'($urandom_range(255)));
            else send_char(buf_q[0]);
            void'(buf_q.pop_front());
            sent++;
            if (sent == n_items / 2) write_start_pos(16'($urandom_range(16'hFFFF)));
        end
        idle_on = 1'b1;
    endtask

    // ---------------- output side ----------------
    always @(posedge i_clk) begin
        m_tready <= !(idle_on && $urandom_range(99) < 6);
    end

    always @(posedge i_clk) begin
        t_token_beat want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (token_beats_q.size() == 0) begin
                $error("unexpected transaction tdata=%h tuser=%b tlast=%b",
                       m_tdata, m_tuser, m_tlast);
                fail_count++;
            end else begin
                want = token_beats_q.pop_front();
                if (m_tdata[7:0] !== want.text) begin
                    $error("text_char exp %h got %h", want.text, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tuser !== want.valid) begin
                    $error("char_valid exp %b got %b", want.valid, m_tuser);
                    fail_count++;
                end
                if (m_tlast !== want.tend) begin
                    $error("token_end exp %b got %b", want.tend, m_tlast);
                    fail_count++;
                end
                if (m_tdata[12:8] !== want.ttype) begin
                    $error("token_type exp %0d got %0d", want.ttype, m_tdata[12:8]);
                    fail_count++;
                end
                if (m_tdata[28:13] !== want.tstart) begin
                    $error("token_start exp %0d got %0d", want.tstart, m_tdata[28:13]);
                    fail_count++;
                end
                if (m_tdata[31:29] !== 3'b000) begin
                    $error("tdata pad exp 0 got %b", m_tdata[31:29]);
                    fail_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        lex_mode = LX_IDLE;
        char_pos = '0;
        tok_begin = '0;
        n_letters = 0;
        n_digits = 0;
        held[0] = '0;
        held[1] = '0;
        n_held = 0;
        has_text = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_start_pos(16'd0);
        test_cells();
        test_sigils();
        test_numbers();
        test_strings();
        test_operators();
        test_odd_bytes();
        test_position_saturation();
        write_start_pos(16'd1000);
        test_random(70);
        drain();

        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
